// ===== design/bfpd_pkg.sv =====
// Shared types and constants for the beacon frame parser / dedup block.
// No dependencies; every other design file imports this package.
package bfpd_pkg;

    // Table depth and derived widths
    localparam int MAX_ENTRIES = 128;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int LIM_W       = (CNT_W > 8) ? CNT_W : 8;

    // Frame layout
    localparam int FRAME_LEN   = 21;
    localparam int POS_W       = 5;
    localparam int ID_W        = 48;
    localparam int EXTRA_W     = 32;

    localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
    localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
    localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
    localparam logic [7:0] CH_FIVE  = 8'h35;  // '5'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

    localparam logic [3:0] MARKER_GOAL = 4'd14;

    // Register reset values
    localparam logic [6:0] RSSI_LIMIT_RST   = 7'd99;
    localparam logic [7:0] WINDOW_LIMIT_RST = 8'd90;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_RSSI_LIMIT   = 1'b0,
        CFG_WINDOW_LIMIT = 1'b1
    } cfg_idx_t;

    // Request operations
    typedef enum logic [0:0] {
        OP_BYTE  = 1'b0,
        OP_CLOSE = 1'b1
    } op_t;

    // Result event codes
    typedef enum logic [2:0] {
        EV_NEW    = 3'd0,
        EV_DUP    = 3'd1,
        EV_RSSI   = 3'd2,
        EV_FULL   = 3'd3,
        EV_CLOSED = 3'd4,
        EV_LINK   = 3'd5
    } event_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_REPORT,
        ST_FULL
    } state_t;

    // Channel payloads
    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [2:0]         event_res;
        logic [ID_W-1:0]    beacon_id;
        logic [EXTRA_W-1:0] beacon_extra;
        logic [6:0]         rssi_level;
        logic [7:0]         unique_count;
        logic               last;
    } result_t;

    // Parsed view of the frame buffer
    typedef struct packed {
        logic               full;       // exactly FRAME_LEN bytes held
        logic               has_five;
        logic               digits_ok;
        logic [6:0]         rssi;
        logic [ID_W-1:0]    id;
        logic [EXTRA_W-1:0] extra;
    } frame_view_t;

    // Search token handed from cell to cell
    typedef struct packed {
        logic valid;
        logic hit;
    } probe_t;

    // Table write broadcast to every cell
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [ID_W-1:0]  data;
    } tbl_wr_t;

endpackage

// ===== design/bfpd_cell.sv =====
// One table cell: holds a single stored ID and compares it against the probe key.
// Depends on bfpd_pkg.
module bfpd_cell
    import bfpd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] idx,
    input  logic [CNT_W-1:0] count,
    input  logic [ID_W-1:0]  key,
    input  tbl_wr_t          wr,
    input  probe_t           probe_in,
    output probe_t           probe_out
);

    logic [ID_W-1:0] entry_reg;
    logic            valid_reg;
    logic            valid_next;
    logic            hit_reg;
    logic            hit_next;
    logic            occupied;

    // Entry store
    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.addr == idx))
        begin
            entry_reg <= wr.data;
        end
    end

    // Compare and pass the token on
    assign occupied   = CNT_W'(idx) < count;
    assign valid_next = probe_in.valid;
    assign hit_next   = probe_in.hit | (probe_in.valid && occupied && (entry_reg == key));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
    end

    assign probe_out.valid = valid_reg;
    assign probe_out.hit   = hit_reg;

endmodule

// ===== design/bfpd_chain.sv =====
// Row of MAX_ENTRIES table cells; the search token walks one cell per clock.
// Depends on bfpd_pkg and bfpd_cell.
module bfpd_chain
    import bfpd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CNT_W-1:0] count,
    input  logic [ID_W-1:0]  key,
    input  tbl_wr_t          wr,
    output logic             done,
    output logic             hit
);

    probe_t links [MAX_ENTRIES+1];

    // Token enters the first cell clean
    assign links[0].valid = start;
    assign links[0].hit   = 1'b0;

    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_cell
        bfpd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .idx       (IDX_W'(g)),
            .count     (count),
            .key       (key),
            .wr        (wr),
            .probe_in  (links[g]),
            .probe_out (links[g+1])
        );
    end

    assign done = links[MAX_ENTRIES].valid;
    assign hit  = links[MAX_ENTRIES].hit;

endmodule

// ===== design/bfpd_frame.sv =====
// Frame collector: byte shift line, saturating position and field decode.
// Depends on bfpd_pkg.
module bfpd_frame
    import bfpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic [7:0]  data_byte,
    output frame_view_t view
);

    logic [7:0]       bytes_reg [FRAME_LEN];   // index 0 holds the newest byte
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             is_colon;
    logic             is_marker;
    logic             shift_en;
    logic [7:0]       d0;
    logic [7:0]       d1;
    logic [3:0]       d0_val;
    logic [3:0]       d1_val;

    assign is_colon  = data_byte == CH_COLON;
    assign is_marker = (data_byte == CH_LT) || (data_byte == CH_GT);
    assign shift_en  = take && !is_colon && !is_marker && (pos_reg < POS_W'(FRAME_LEN));

    // Position: cleared by ':', saturates one past a full frame
    always_comb
    begin
        pos_next = pos_reg;
        if (take && is_colon)
        begin
            pos_next = '0;
        end
        else if (take && !is_marker)
        begin
            if (pos_reg < POS_W'(FRAME_LEN))
            begin
                pos_next = pos_reg + POS_W'(1);
            end
            else
            begin
                pos_next = POS_W'(FRAME_LEN + 1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    // Shift line
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            bytes_reg[0] <= data_byte;
            for (int i = 1; i < FRAME_LEN; i++)
            begin
                bytes_reg[i] <= bytes_reg[i-1];
            end
        end
    end

    // Field decode; frame offset k sits at bytes_reg[FRAME_LEN-1-k]
    assign d0     = bytes_reg[FRAME_LEN-1-19];
    assign d1     = bytes_reg[FRAME_LEN-1-20];
    assign d0_val = d0[3:0];
    assign d1_val = d1[3:0];

    always_comb
    begin
        view.full      = pos_reg == POS_W'(FRAME_LEN);
        view.has_five  = (bytes_reg[FRAME_LEN-1-13] == CH_FIVE) ||
                         (bytes_reg[FRAME_LEN-1-14] == CH_FIVE);
        view.digits_ok = (d0 inside {[CH_ZERO:CH_NINE]}) && (d1 inside {[CH_ZERO:CH_NINE]});
        view.rssi      = 7'(d0_val) * 7'd10 + 7'(d1_val);
        view.id        = '0;
        for (int k = 2; k <= 7; k++)
        begin
            view.id = {view.id[ID_W-9:0], bytes_reg[FRAME_LEN-1-k]};
        end
        view.extra = '0;
        for (int k = 12; k <= 15; k++)
        begin
            view.extra = {view.extra[EXTRA_W-9:0], bytes_reg[FRAME_LEN-1-k]};
        end
    end

endmodule

// ===== design/beacon_frame_parse_dedup_top.sv =====
// Top level of the beacon frame parser with per-window ID de-duplication.
// Depends on bfpd_pkg, bfpd_frame and bfpd_chain.
//
// Scanner bytes and window-close requests enter on the item channel; results leave on the
// res channel through a one-entry output register. Requests are taken only in the idle state
// and only while the output register is free. A ':' that closes a valid 21-byte frame with
// an acceptable RSSI starts a table search: the probe walks the row of MAX_ENTRIES cells one
// cell per clock, and no request is taken until the frame's report, and a window-full report
// if one is due, has been loaded into the output register. Frames rejected on RSSI report
// without a search. The ID table needs no clearing pass after reset.
module beacon_frame_parse_dedup_top
    import bfpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  item_t      item,
    output logic       res_valid,
    input  logic       res_stall,
    output result_t    res,
    input  logic       cfg_write,
    input  cfg_idx_t   cfg_index,
    input  logic [7:0] cfg_data
);

    state_t             state_reg;
    state_t             state_next;
    logic [6:0]         rssi_limit_reg;
    logic [7:0]         window_limit_reg;
    logic [3:0]         marker_reg;
    logic [3:0]         marker_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   count_inc;
    logic               res_valid_reg;
    logic               res_valid_next;
    result_t            res_reg;
    result_t            res_next;
    logic [ID_W-1:0]    pend_id_reg;
    logic [ID_W-1:0]    pend_id_next;
    logic [EXTRA_W-1:0] pend_extra_reg;
    logic [EXTRA_W-1:0] pend_extra_next;
    logic [6:0]         pend_rssi_reg;
    logic [6:0]         pend_rssi_next;
    logic               pend_hit_reg;
    logic               pend_hit_next;
    logic               search_armed_reg;
    logic               res_free;
    logic               accept;
    logic               frame_take;
    logic               chain_done;
    logic               chain_hit;
    logic [LIM_W-1:0]   lim;
    frame_view_t        view;
    tbl_wr_t            tbl_wr;

    function automatic result_t make_res(event_t ev, logic [ID_W-1:0] id,
                                         logic [EXTRA_W-1:0] extra, logic [6:0] rssi,
                                         logic [CNT_W-1:0] cnt, logic last);
        result_t r;
        r.event_res    = ev;
        r.beacon_id    = id;
        r.beacon_extra = extra;
        r.rssi_level   = rssi;
        r.unique_count = 8'(cnt);
        r.last         = last;
        return r;
    endfunction

    assign res_free   = !res_valid_reg || !res_stall;
    assign accept     = item_valid && !item_stall;
    assign frame_take = accept && (item.operation == OP_BYTE);

    // Effective window limit: zero acts as one, clamp to table depth
    always_comb
    begin
        lim = LIM_W'(window_limit_reg);
        if (window_limit_reg == 8'd0)
        begin
            lim = LIM_W'(1);
        end
        if (lim > LIM_W'(MAX_ENTRIES))
        begin
            lim = LIM_W'(MAX_ENTRIES);
        end
    end

    assign count_inc = count_reg + CNT_W'(1);

    // Frame collector
    bfpd_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (frame_take),
        .data_byte (item.data_byte),
        .view      (view)
    );

    // ID table row, launched by the armed flag, which is registered together with the key
    bfpd_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .start (search_armed_reg),
        .count (count_reg),
        .key   (pend_id_reg),
        .wr    (tbl_wr),
        .done  (chain_done),
        .hit   (chain_hit)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rssi_limit_reg   <= RSSI_LIMIT_RST;
            window_limit_reg <= WINDOW_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_RSSI_LIMIT:   rssi_limit_reg   <= cfg_data[6:0];
                CFG_WINDOW_LIMIT: window_limit_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Controller: next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        marker_next     = marker_reg;
        count_next      = count_reg;
        res_valid_next  = res_valid_reg && res_stall;
        res_next        = res_reg;
        pend_id_next    = pend_id_reg;
        pend_extra_next = pend_extra_reg;
        pend_rssi_next  = pend_rssi_reg;
        pend_hit_next   = pend_hit_reg;
        item_stall      = 1'b1;
        tbl_wr.en       = 1'b0;
        tbl_wr.addr     = count_reg[IDX_W-1:0];
        tbl_wr.data     = pend_id_reg;

        case (state_reg)
            ST_IDLE:
            begin
                item_stall = !res_free;
                if (item_valid && res_free)
                begin
                    if (item.operation == OP_CLOSE)
                    begin
                        res_next       = make_res(EV_CLOSED, '0, '0, '0, count_reg, 1'b1);
                        res_valid_next = 1'b1;
                        count_next     = '0;
                    end
                    else if (item.data_byte == CH_COLON)
                    begin
                        if (view.full && view.has_five)
                        begin
                            if (!view.digits_ok)
                            begin
                                res_next = make_res(EV_RSSI, view.id, view.extra, '0,
                                                    count_reg, 1'b1);
                                res_valid_next = 1'b1;
                            end
                            else if (view.rssi > rssi_limit_reg)
                            begin
                                res_next = make_res(EV_RSSI, view.id, view.extra, view.rssi,
                                                    count_reg, 1'b1);
                                res_valid_next = 1'b1;
                            end
                            else
                            begin
                                pend_id_next    = view.id;
                                pend_extra_next = view.extra;
                                pend_rssi_next  = view.rssi;
                                state_next      = ST_SEARCH;
                            end
                        end
                    end
                    else if ((item.data_byte == CH_LT) || (item.data_byte == CH_GT))
                    begin
                        if (marker_reg + 4'd1 >= MARKER_GOAL)
                        begin
                            marker_next    = '0;
                            res_next       = make_res(EV_LINK, '0, '0, '0, count_reg, 1'b1);
                            res_valid_next = 1'b1;
                        end
                        else
                        begin
                            marker_next = marker_reg + 4'd1;
                        end
                    end
                end
            end

            ST_SEARCH:
            begin
                if (chain_done)
                begin
                    pend_hit_next = chain_hit;
                    state_next    = ST_REPORT;
                end
            end

            ST_REPORT:
            begin
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    if (pend_hit_reg)
                    begin
                        res_next   = make_res(EV_DUP, pend_id_reg, pend_extra_reg,
                                              pend_rssi_reg, count_reg, 1'b1);
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        tbl_wr.en  = 1'b1;
                        count_next = count_inc;
                        if (LIM_W'(count_inc) >= lim)
                        begin
                            res_next   = make_res(EV_NEW, pend_id_reg, pend_extra_reg,
                                                  pend_rssi_reg, count_inc, 1'b0);
                            state_next = ST_FULL;
                        end
                        else
                        begin
                            res_next   = make_res(EV_NEW, pend_id_reg, pend_extra_reg,
                                                  pend_rssi_reg, count_inc, 1'b1);
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            ST_FULL:
            begin
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    res_next       = make_res(EV_FULL, pend_id_reg, pend_extra_reg,
                                              pend_rssi_reg, count_reg, 1'b1);
                    count_next     = '0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Search launch: first clock in the search state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_armed_reg <= 1'b0;
        end
        else
        begin
            search_armed_reg <= (state_reg != ST_SEARCH) && (state_next == ST_SEARCH);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            marker_reg    <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
            pend_hit_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            marker_reg    <= marker_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
            pend_hit_reg  <= (state_reg == ST_IDLE) ? 1'b0 : pend_hit_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        res_reg        <= res_next;
        pend_id_reg    <= pend_id_next;
        pend_extra_reg <= pend_extra_next;
        pend_rssi_reg  <= pend_rssi_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // The row is launched only from the search state
    assign_probe: assert property (@(posedge clk) disable iff (!rst_n)
        search_armed_reg |-> state_reg == ST_SEARCH)
        else $error("search launch outside search state");

    // Table count never passes the table depth
    count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("table count beyond depth");

    // No request is taken while a search is under way
    search_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH || state_reg == ST_REPORT) |-> !accept)
        else $error("request accepted during search");

    // A table write always lands below the depth
    write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_wr.en |-> count_reg < CNT_W'(MAX_ENTRIES))
        else $error("table write past depth");

    // A window-full report always follows a new-beacon report
    full_after_new: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REPORT && state_next == ST_FULL) |=>
            res_valid && res.event_res == EV_NEW && !res.last)
        else $error("window full without preceding new report");

endmodule
